/* src/mtt_pkg.sv */
// Shared types, constants and state encoding for the point mover.
package mtt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int AXES          = 3;
    localparam int ROOT_W        = 33;
    localparam int SQRT_ITERS    = 33;
    localparam int DIV_ITERS     = 33;
    localparam int CNT_W         = 6;
    localparam int SEL_W         = 2;
    localparam int PADDR_W       = 3;

    localparam logic OP_STEP = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic REG_SPEED = 1'b0;

    typedef struct packed {
        logic        op;
        logic [31:0] target_x;
        logic [31:0] target_y;
        logic [31:0] target_z;
        logic [15:0] time_step;
    } req_t;

    typedef struct packed {
        logic        moving;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIFF,
        ST_SQ,
        ST_RINIT,
        ST_ROOT,
        ST_DECIDE,
        ST_MUL,
        ST_DINIT,
        ST_DIV,
        ST_MOVE,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic             capture;
        logic             diff;
        logic             acc_en;
        logic             root_init;
        logic             root_step;
        logic             prod_en;
        logic             div_init;
        logic             div_step;
        logic             move;
        logic             snap;
        logic             snap_moving;
        logic             out_load;
        logic [SEL_W-1:0] sel;
    } cmd_t;

    typedef struct packed {
        logic op_load;
        logic arrive;
        logic over;
    } status_t;

endpackage

/* src/mtt_ctrl.sv */
// Sequencer for the point mover: walks each word through the datapath phases.
module mtt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             rsp_stall,
    input  mtt_pkg::status_t status,
    output mtt_pkg::cmd_t    cmd,
    output logic             req_stall,
    output logic             rsp_valid
);
    import mtt_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic             accept;
    logic             out_free;

    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                    state_next = (status.op_load == OP_LOAD) ? ST_LOAD : ST_DIFF;
            end
            ST_LOAD:  state_next = ST_FIN;
            ST_DIFF:  state_next = ST_SQ;
            ST_SQ:
            begin
                if (cnt_reg == CNT_W'(AXES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_RINIT;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_RINIT: state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (cnt_reg == CNT_W'(SQRT_ITERS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DECIDE;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DECIDE:
            begin
                if (status.arrive || status.over)
                    state_next = ST_FIN;
                else
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (cnt_reg == CNT_W'(AXES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DINIT;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DINIT: state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_ITERS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_MOVE;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_MOVE:  state_next = ST_FIN;
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        cmd.sel        = cnt_reg[SEL_W-1:0];
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            ST_IDLE:   cmd.capture = accept;
            ST_LOAD:   cmd.snap = 1'b1;
            ST_DIFF:   cmd.diff = 1'b1;
            ST_SQ:     cmd.acc_en = 1'b1;
            ST_RINIT:  cmd.root_init = 1'b1;
            ST_ROOT:   cmd.root_step = 1'b1;
            ST_DECIDE:
            begin
                // arrival wins over overshoot
                cmd.snap        = status.arrive || status.over;
                cmd.snap_moving = !status.arrive;
            end
            ST_MUL:    cmd.prod_en = 1'b1;
            ST_DINIT:  cmd.div_init = 1'b1;
            ST_DIV:    cmd.div_step = 1'b1;
            ST_MOVE:   cmd.move = 1'b1;
            ST_FIN:
            begin
                cmd.out_load = out_free;
                if (out_free)
                    rsp_valid_next = 1'b1;
            end
            default:   cmd = '0;
        endcase
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("controller still idle after accepting a word");

    a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT && cnt_reg == CNT_W'(SQRT_ITERS - 1)) |=>
        (state_reg == ST_DECIDE))
        else $error("square root did not hand over to decision");

    a_rsp_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside finish state");

endmodule

/* src/mtt_dpath.sv */
// Datapath: differences, shared multiplier, digit square root, three dividers.
module mtt_dpath #(
    parameter int FRAC_BITS = mtt_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [31:0]      speed,
    input  mtt_pkg::req_t    req,
    input  mtt_pkg::cmd_t    cmd,
    output mtt_pkg::status_t status,
    output mtt_pkg::rsp_t    rsp
);
    import mtt_pkg::*;

    localparam int THRESH = ((1 << FRAC_BITS) + 5) / 10;

    logic [31:0]       tgt_reg  [AXES];
    logic [31:0]       pos_reg  [AXES];
    logic [32:0]       mag_reg  [AXES];
    logic              neg_reg  [AXES];
    logic [64:0]       prod_reg [AXES];
    logic [33:0]       drem_reg [AXES];
    logic [32:0]       dnum_reg [AXES];
    logic [32:0]       q_reg    [AXES];
    logic [15:0]       ts_reg;
    logic [31:0]       step_reg;
    logic [65:0]       acc_reg;
    logic [65:0]       rad_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [35:0]       rem_reg;
    logic              moving_reg;
    rsp_t              rsp_reg;

    logic [32:0] diff     [AXES];
    logic [32:0] mag_abs  [AXES];
    logic [33:0] dr_sh    [AXES];
    logic        dr_ge    [AXES];
    logic [47:0] step_full;
    logic [32:0] mag_sel;
    logic [32:0] mul_b;
    logic [65:0] mul_p;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        root_ge;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            diff[i]    = {tgt_reg[i][31], tgt_reg[i]} - {pos_reg[i][31], pos_reg[i]};
            mag_abs[i] = diff[i][32] ? (33'd0 - diff[i]) : diff[i];
            dr_sh[i]   = {drem_reg[i][32:0], dnum_reg[i][32]};
            dr_ge[i]   = dr_sh[i] >= {1'b0, root_reg};
        end
    end

    assign step_full = 48'(speed) * 48'(ts_reg);

    always_comb
    begin
        unique case (cmd.sel)
            2'd1:    mag_sel = mag_reg[1];
            2'd2:    mag_sel = mag_reg[2];
            default: mag_sel = mag_reg[0];
        endcase
        mul_b = cmd.prod_en ? {1'b0, step_reg} : mag_sel;
        mul_p = 66'(mag_sel) * 66'(mul_b);
    end

    // one result bit per cycle, two radicand bits in
    assign rem_sh  = {rem_reg[33:0], rad_reg[65:64]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign root_ge = rem_sh >= trial;

    assign status.op_load = req.op;
    assign status.arrive  = root_reg <= ROOT_W'(THRESH);
    assign status.over    = {1'b0, step_reg} > root_reg;
    assign rsp            = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
                pos_reg[i] <= '0;
            moving_reg <= 1'b0;
        end
        else if (cmd.snap)
        begin
            for (int i = 0; i < AXES; i++)
                pos_reg[i] <= tgt_reg[i];
            moving_reg <= cmd.snap_moving;
        end
        else if (cmd.move)
        begin
            for (int i = 0; i < AXES; i++)
                pos_reg[i] <= neg_reg[i] ? pos_reg[i] - q_reg[i][31:0]
                                         : pos_reg[i] + q_reg[i][31:0];
            moving_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tgt_reg[0] <= req.target_x;
            tgt_reg[1] <= req.target_y;
            tgt_reg[2] <= req.target_z;
            ts_reg     <= req.time_step;
        end
        if (cmd.diff)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                mag_reg[i] <= mag_abs[i];
                neg_reg[i] <= diff[i][32];
            end
            step_reg <= step_full[47:16];
            acc_reg  <= '0;
        end
        if (cmd.acc_en)
            acc_reg <= acc_reg + mul_p;
        if (cmd.root_init)
        begin
            rad_reg  <= acc_reg;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        if (cmd.root_step)
        begin
            rem_reg  <= root_ge ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], root_ge};
            rad_reg  <= {rad_reg[63:0], 2'b00};
        end
        if (cmd.prod_en)
        begin
            for (int i = 0; i < AXES; i++)
                if (cmd.sel == SEL_W'(i))
                    prod_reg[i] <= mul_p[64:0];
        end
        // quotient fits 33 bits since |d| * step <= dist^2
        if (cmd.div_init)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                drem_reg[i] <= {2'b00, prod_reg[i][64:33]};
                dnum_reg[i] <= prod_reg[i][32:0];
                q_reg[i]    <= '0;
            end
        end
        if (cmd.div_step)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                drem_reg[i] <= dr_ge[i] ? dr_sh[i] - {1'b0, root_reg} : dr_sh[i];
                dnum_reg[i] <= {dnum_reg[i][31:0], 1'b0};
                q_reg[i]    <= {q_reg[i][31:0], dr_ge[i]};
            end
        end
        if (cmd.out_load)
        begin
            rsp_reg.moving <= moving_reg;
            rsp_reg.pos_x  <= pos_reg[0];
            rsp_reg.pos_y  <= pos_reg[1];
            rsp_reg.pos_z  <= pos_reg[2];
        end
    end

endmodule

/* src/move_toward_target_clamped.sv */
// Top level of the 3-D point mover: config register, sequencer and datapath.
//
// Usage:
//   req channel (req_valid / req_stall / req) carries one word per command:
//   op = step moves the held position toward the target by speed * time_step,
//   op = load sets the position to the target fields.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns one word per command:
//   the moving flag and the new position.
//   speed is written over the APB port at byte address 0, by the user only
//   while idle; the block itself does not enforce this.
// Sequence (one word in flight at a time), from acceptance to rsp_valid:
//   load: snap the position to the target, then load the output register.
//   step that snaps (arrival or overshoot): differences, sum of squares,
//   square root of the squared distance, decision, snap, output register.
//   step that moves: the same up to the decision, then the three products,
//   the divide (three dividers side by side), the move, the output register.
//   A new word is taken once the last one sits in the output register, even
//   while rsp_stall holds it; the block then waits at its finish step.
// Reset: position clears to zero, speed returns to 1.0, no result pending.
module move_toward_target_clamped #(
    parameter int FRAC_BITS = mtt_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mtt_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  mtt_pkg::req_t               req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output mtt_pkg::rsp_t               rsp
);
    import mtt_pkg::*;

    localparam logic [31:0] SPEED_RESET = 32'(64'd1 << FRAC_BITS);

    logic [31:0] speed_reg, speed_next;
    logic        cfg_wr;
    cmd_t        cmd;
    status_t     status;

    // config register, word index from the upper address bit
    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_SPEED);
    assign speed_next = cfg_wr ? pwdata : speed_reg;
    assign prdata     = (paddr[PADDR_W-1] == REG_SPEED) ? speed_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            speed_reg <= SPEED_RESET;
        else
            speed_reg <= speed_next;
    end

    mtt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid)
    );

    mtt_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .speed  (speed_reg),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .rsp    (rsp)
    );

endmodule
